@@ hw/rtl/tmp_pkg.sv @@
// Shared types and constants for the triangular motion profile block.
// No dependencies; every other file imports this package.
package tmp_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int PHASE_WIDTH  = 17;
    localparam int TIME_WIDTH   = 24;
    localparam int MAG_WIDTH    = COORD_WIDTH + 1;
    localparam int M_WIDTH      = 16;
    localparam int K_WIDTH      = M_WIDTH + 2;
    localparam int FRAC_WIDTH   = 32;
    localparam int LO_WIDTH     = 16;
    localparam int HI_WIDTH     = MAG_WIDTH - LO_WIDTH;
    localparam int PROD_WIDTH   = MAG_WIDTH + K_WIDTH;
    localparam int SUM_WIDTH    = MAG_WIDTH + FRAC_WIDTH + 1;
    localparam int DIV_WIDTH    = TIME_WIDTH + COORD_WIDTH + 1;
    localparam int NUM_AXES     = 3;
    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = COORD_WIDTH;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

    localparam logic [PHASE_WIDTH-1:0] PHASE_ONE  = PHASE_WIDTH'(65536);
    localparam logic [PHASE_WIDTH-1:0] PHASE_HALF = PHASE_WIDTH'(32768);
    localparam logic [FRAC_WIDTH-1:0]  FRAC_ONE   = FRAC_WIDTH'(64'h8000_0000);
    localparam logic [SUM_WIDTH-1:0]   ROUND_HALF = SUM_WIDTH'(64'h4000_0000);
    localparam int                     FRAC_SHIFT = 31;

    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;
    localparam logic REG_MOVE_TIME = 1'b0;
    localparam logic [TIME_WIDTH-1:0] MOVE_TIME_RESET = TIME_WIDTH'(65536);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [TIME_WIDTH-1:0]         mtime_t;
    typedef logic [DIV_WIDTH-1:0]          dvd_t;

    typedef struct packed {
        coord_t                 point;
        logic [COORD_WIDTH-1:0] quot;
        logic                   neg;
        logic                   ovf;
    } lane_out_t;

endpackage

@@ hw/rtl/tmp_if.sv @@
// Stream interfaces for input items and result items.
// Depends on tmp_pkg.
interface tmp_in_if;
    import tmp_pkg::*;
    logic                   valid;
    logic                   ready;
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 start_z;
    coord_t                 goal_x;
    coord_t                 goal_y;
    coord_t                 goal_z;
    logic [PHASE_WIDTH-1:0] progress;

    modport source (output valid, start_x, start_y, start_z, goal_x, goal_y, goal_z,
                    progress, input ready);
    modport sink   (input valid, start_x, start_y, start_z, goal_x, goal_y, goal_z,
                    progress, output ready);
endinterface

interface tmp_out_if;
    import tmp_pkg::*;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t speed_x;
    coord_t speed_y;
    coord_t speed_z;
    logic   finished;

    modport source (output valid, point_x, point_y, point_z, speed_x, speed_y, speed_z,
                    finished, input ready);
    modport sink   (input valid, point_x, point_y, point_z, speed_x, speed_y, speed_z,
                    finished, output ready);
endinterface

@@ hw/rtl/tmp_axis_front.sv @@
// Front half of one axis: distance, position blend and speed dividend (4 stages).
// Depends on tmp_pkg.
module tmp_axis_front (
    input  logic                            clk,
    input  logic                            adv,
    input  tmp_pkg::coord_t                 start,
    input  tmp_pkg::coord_t                 goal,
    input  logic [tmp_pkg::FRAC_WIDTH-1:0]  frac,
    input  logic [tmp_pkg::K_WIDTH-1:0]     kval,
    input  tmp_pkg::mtime_t                 tdiv,
    input  logic                            fin,
    output tmp_pkg::coord_t                 point,
    output tmp_pkg::dvd_t                   dividend,
    output logic                            neg,
    output logic                            ovf
);
    import tmp_pkg::*;

    // stage 1
    logic [MAG_WIDTH-1:0] mag1_reg, mag1_next;
    logic                 neg1_reg, neg1_next;
    coord_t               s1_reg, g1_reg;
    // stage 2
    logic [HI_WIDTH+FRAC_WIDTH-1:0] ph2_reg;
    logic [LO_WIDTH+FRAC_WIDTH-1:0] pl2_reg;
    logic [PROD_WIDTH-1:0]          pv2_reg;
    logic                           neg2_reg;
    coord_t                         s2_reg, g2_reg;
    // stage 3
    logic [MAG_WIDTH-1:0] off3_reg, off3_next;
    dvd_t                 dvd3_reg, dvd3_next;
    logic                 neg3_reg;
    coord_t               s3_reg, g3_reg;
    // stage 4
    coord_t pt4_reg, pt4_next;
    dvd_t   dvd4_reg;
    logic   neg4_reg, ovf4_reg, ovf4_next;

    logic signed [MAG_WIDTH-1:0] diff;
    logic [SUM_WIDTH-1:0]        sum3;
    logic signed [MAG_WIDTH:0]   pt_wide;

    always_comb
    begin
        diff      = MAG_WIDTH'(goal) - MAG_WIDTH'(start);
        neg1_next = diff[MAG_WIDTH-1];
        mag1_next = neg1_next ? MAG_WIDTH'(-diff) : MAG_WIDTH'(diff);
    end

    always_comb
    begin
        // round(mag * frac / 2^31), ties away from zero
        sum3      = (SUM_WIDTH'(ph2_reg) << LO_WIDTH) + SUM_WIDTH'(pl2_reg) + ROUND_HALF;
        off3_next = MAG_WIDTH'(sum3 >> FRAC_SHIFT);
        dvd3_next = DIV_WIDTH'(pv2_reg) + DIV_WIDTH'(tdiv >> 1);
    end

    always_comb
    begin
        if (neg3_reg)
            pt_wide = (MAG_WIDTH+1)'(s3_reg) - (MAG_WIDTH+1)'(off3_reg);
        else
            pt_wide = (MAG_WIDTH+1)'(s3_reg) + (MAG_WIDTH+1)'(off3_reg);
        pt4_next  = fin ? g3_reg : COORD_WIDTH'(pt_wide);
        ovf4_next = dvd3_reg >= (DIV_WIDTH'(tdiv) << COORD_WIDTH);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            s1_reg   <= start;
            g1_reg   <= goal;

            pl2_reg  <= mag1_reg[LO_WIDTH-1:0] * frac;
            ph2_reg  <= mag1_reg[MAG_WIDTH-1:LO_WIDTH] * frac;
            pv2_reg  <= mag1_reg * kval;
            neg2_reg <= neg1_reg;
            s2_reg   <= s1_reg;
            g2_reg   <= g1_reg;

            off3_reg <= off3_next;
            dvd3_reg <= dvd3_next;
            neg3_reg <= neg2_reg;
            s3_reg   <= s2_reg;
            g3_reg   <= g2_reg;

            pt4_reg  <= pt4_next;
            dvd4_reg <= dvd3_reg;
            neg4_reg <= neg3_reg;
            ovf4_reg <= ovf4_next;
        end
    end

    assign point    = pt4_reg;
    assign dividend = dvd4_reg;
    assign neg      = neg4_reg;
    assign ovf      = ovf4_reg;

endmodule

@@ hw/rtl/tmp_div_lane.sv @@
// Restoring divider for one axis, one quotient bit per stage.
// Depends on tmp_pkg.
module tmp_div_lane (
    input  logic                clk,
    input  logic                adv,
    input  tmp_pkg::mtime_t     tdiv,
    input  tmp_pkg::dvd_t       dividend,
    input  tmp_pkg::coord_t     point,
    input  logic                neg,
    input  logic                ovf,
    output tmp_pkg::lane_out_t  result
);
    import tmp_pkg::*;

    dvd_t                   rem_reg  [DIV_STAGES];
    logic [COORD_WIDTH-1:0] quot_reg [DIV_STAGES];
    coord_t                 pt_reg   [DIV_STAGES];
    logic                   neg_reg  [DIV_STAGES];
    logic                   ovf_reg  [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        localparam int BIT = DIV_STAGES - 1 - i;
        dvd_t                   rem_in;
        logic [COORD_WIDTH-1:0] quot_in;
        coord_t                 pt_in;
        logic                   neg_in;
        logic                   ovf_in;
        logic [DIV_WIDTH:0]     cand;
        dvd_t                   rem_next;
        logic [COORD_WIDTH-1:0] quot_next;

        if (i == 0)
        begin : g_first
            assign rem_in  = dividend;
            assign quot_in = '0;
            assign pt_in   = point;
            assign neg_in  = neg;
            assign ovf_in  = ovf;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign pt_in   = pt_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign ovf_in  = ovf_reg[i-1];
        end

        always_comb
        begin
            cand      = {1'b0, rem_in} - ((DIV_WIDTH+1)'(tdiv) << BIT);
            rem_next  = cand[DIV_WIDTH] ? rem_in : cand[DIV_WIDTH-1:0];
            quot_next = quot_in;
            quot_next[BIT] = ~cand[DIV_WIDTH];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                quot_reg[i] <= quot_next;
                pt_reg[i]   <= pt_in;
                neg_reg[i]  <= neg_in;
                ovf_reg[i]  <= ovf_in;
            end
        end
    end

    assign result.point = pt_reg[DIV_STAGES-1];
    assign result.quot  = quot_reg[DIV_STAGES-1];
    assign result.neg   = neg_reg[DIV_STAGES-1];
    assign result.ovf   = ovf_reg[DIV_STAGES-1];

endmodule

@@ hw/rtl/triangular_motion_profile_core.sv @@
// Top level of the triangular motion profile block: APB register, phase math,
// three axis lanes and the output register. Depends on tmp_pkg, tmp_if,
// tmp_axis_front and tmp_div_lane.
//
// Usage:
//   in_item  : start point, goal point and phase (Q1.16) per item.
//   out_item : commanded point, velocity and finished flag, one per item.
//   APB      : register 0 (byte 0) is move_time, Q8.16 seconds; a value of
//              zero acts as the smallest move time. Write it only while idle.
// Pipeline: 4 front stages + 32 divider stages + the output register; the first
//   front stage loads at the edge that accepts its item.
// Throughput: one item per cycle unless stalled (see Stall). The speed division is a 32-stage
//   restoring divider per axis, one quotient bit a stage.
// Reset: empties the pipeline and sets move_time to one second.
// Stall: the whole pipeline holds while the output register is full and
//   out_item.ready is low; in_item.ready drops for exactly those cycles,
//   so nothing is lost or repeated.
module triangular_motion_profile_core (
    input  logic                            clk,
    input  logic                            rst_n,
    tmp_in_if.sink                          in_item,
    tmp_out_if.source                       out_item,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmp_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [tmp_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [tmp_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import tmp_pkg::*;

    // ---------------- configuration ----------------
    mtime_t move_time_reg, move_time_next;
    mtime_t tdiv;
    logic   reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];

    always_comb
    begin
        move_time_next = move_time_reg;
        if (psel && penable && pwrite && reg_index == REG_MOVE_TIME)
            move_time_next = pwdata[TIME_WIDTH-1:0];
    end

    always_comb
    begin
        if (reg_index == REG_MOVE_TIME)
            prdata = DATA_WIDTH'(move_time_reg);
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            move_time_reg <= MOVE_TIME_RESET;
        else
            move_time_reg <= move_time_next;
    end

    // zero move time behaves as the smallest one
    assign tdiv = (move_time_reg == '0) ? TIME_WIDTH'(1) : move_time_reg;

    // ---------------- pipeline control ----------------
    // All stages move together; a bubble costs nothing since the pipe
    // only holds when the output register is full and not taken.
    logic adv;
    logic out_vld_reg;
    logic vld_reg [PIPE_DEPTH];
    logic fin_reg [PIPE_DEPTH];

    assign adv           = !out_vld_reg || out_item.ready;
    assign in_item.ready = adv;

    // ---------------- phase math (feeds stage 1) ----------------
    logic                   low_half;
    logic [M_WIDTH-1:0]     m_in;
    logic [FRAC_WIDTH-1:0]  msq;
    logic [FRAC_WIDTH-1:0]  frac_next, frac1_reg;
    logic [K_WIDTH-1:0]     k_next, k1_reg;
    logic                   fin_next;

    always_comb
    begin
        low_half  = in_item.progress < PHASE_HALF;
        m_in      = low_half ? in_item.progress[M_WIDTH-1:0]
                             : M_WIDTH'(PHASE_ONE - in_item.progress);
        msq       = FRAC_WIDTH'(m_in) * FRAC_WIDTH'(m_in);
        // fraction in Q0.31: 2p^2 below the midpoint, 1-2(1-p)^2 above
        frac_next = low_half ? msq : FRAC_ONE - msq;
        k_next    = {m_in, 2'b00};
        fin_next  = in_item.progress > PHASE_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frac1_reg <= frac_next;
            k1_reg    <= k_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
                fin_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_item.valid;
            fin_reg[0] <= fin_next;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
                fin_reg[i] <= fin_reg[i-1];
            end
        end
    end

    // ---------------- axis lanes ----------------
    coord_t    start_a [NUM_AXES];
    coord_t    goal_a  [NUM_AXES];
    lane_out_t lane_res[NUM_AXES];
    coord_t    pt_next [NUM_AXES];
    coord_t    sp_next [NUM_AXES];
    coord_t    pt_reg  [NUM_AXES];
    coord_t    sp_reg  [NUM_AXES];
    logic      fin_out_reg;

    assign start_a[0] = in_item.start_x;
    assign start_a[1] = in_item.start_y;
    assign start_a[2] = in_item.start_z;
    assign goal_a[0]  = in_item.goal_x;
    assign goal_a[1]  = in_item.goal_y;
    assign goal_a[2]  = in_item.goal_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        coord_t                 f_point;
        dvd_t                   f_dvd;
        logic                   f_neg;
        logic                   f_ovf;
        logic [COORD_WIDTH-1:0] limit;
        logic [COORD_WIDTH-1:0] mag;

        tmp_axis_front u_front (
            .clk      (clk),
            .adv      (adv),
            .start    (start_a[a]),
            .goal     (goal_a[a]),
            .frac     (frac1_reg),
            .kval     (k1_reg),
            .tdiv     (tdiv),
            .fin      (fin_reg[2]),
            .point    (f_point),
            .dividend (f_dvd),
            .neg      (f_neg),
            .ovf      (f_ovf)
        );

        tmp_div_lane u_div (
            .clk      (clk),
            .adv      (adv),
            .tdiv     (tdiv),
            .dividend (f_dvd),
            .point    (f_point),
            .neg      (f_neg),
            .ovf      (f_ovf),
            .result   (lane_res[a])
        );

        // saturate to the signed range, then apply the sign
        always_comb
        begin
            limit = lane_res[a].neg ? (COORD_WIDTH'(1) << (COORD_WIDTH-1))
                                    : ((COORD_WIDTH'(1) << (COORD_WIDTH-1)) - 1'b1);
            if (lane_res[a].ovf || lane_res[a].quot > limit)
                mag = limit;
            else
                mag = lane_res[a].quot;
            pt_next[a] = lane_res[a].point;
            if (fin_reg[PIPE_DEPTH-1])
                sp_next[a] = '0;
            else if (lane_res[a].neg)
                sp_next[a] = coord_t'(-mag);
            else
                sp_next[a] = coord_t'(mag);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pt_reg[a] <= pt_next[a];
                sp_reg[a] <= sp_next[a];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
            fin_out_reg <= fin_reg[PIPE_DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[PIPE_DEPTH-1];
    end

    assign out_item.valid    = out_vld_reg;
    assign out_item.point_x  = pt_reg[0];
    assign out_item.point_y  = pt_reg[1];
    assign out_item.point_z  = pt_reg[2];
    assign out_item.speed_x  = sp_reg[0];
    assign out_item.speed_y  = sp_reg[1];
    assign out_item.speed_z  = sp_reg[2];
    assign out_item.finished = fin_out_reg;

endmodule
